/* rtl/core/dmx_pkg.sv */
// ----------------------------------------------------------------------------
// DMX slot receiver package
// Shared widths, reset values and the structs that pass between the frame
// controller and the top level.
// ----------------------------------------------------------------------------
package dmx_pkg;

   localparam int SLOTS_DEFAULT = 512;
   localparam int LEVEL_W       = 8;
   localparam int SLOT_NUM_W    = 10;
   localparam int STORE_IDX_W   = 9;

   localparam logic [SLOT_NUM_W-1:0] SLOT_ADDRESS_RESET = 10'd1;

   typedef struct packed {
      logic                   en;
      logic [STORE_IDX_W-1:0] addr;
      logic [LEVEL_W-1:0]     data;
   } wr_cmd_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]    level;
      logic                  level_on;
      logic                  slot_written;
      logic [SLOT_NUM_W-1:0] slot_number;
   } result_type;

endpackage

/* rtl/core/dmx_if.sv */
// ----------------------------------------------------------------------------
// DMX slot receiver channels
// Valid/ready interfaces for received bytes, results and the address register.
// ----------------------------------------------------------------------------
interface dmx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       break_seen;

   modport source (output valid, rx_byte, break_seen, input ready);
   modport sink (input valid, rx_byte, break_seen, output ready);
endinterface

interface dmx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] level;
   logic       level_on;
   logic       slot_written;
   logic [9:0] slot_number;

   modport source (output valid, level, level_on, slot_written, slot_number, input ready);
   modport sink (input valid, level, level_on, slot_written, slot_number, output ready);
endinterface

interface dmx_csr_if;
   logic       valid;
   logic       ready;
   logic [9:0] slot_address;

   modport source (output valid, slot_address, input ready);
   modport sink (input valid, slot_address, output ready);
endinterface

/* rtl/core/dmx512_slot_receiver.sv */
// ----------------------------------------------------------------------------
// DMX512 slot receiver
// A byte is registered in the input stage, then its result in the result stage.
// Throughput: one byte per cycle if rsp_ch is ready; one slot write per cycle.
// Reset: synchronous; the slot store needs no clearing pass, a fill mark makes
// slots not yet written read as zero. The slot address resets to 1.
// ----------------------------------------------------------------------------
module dmx512_slot_receiver
   import dmx_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dmx_req_if.sink   req_ch,
   dmx_rsp_if.source rsp_ch,
   dmx_csr_if.sink   csr_ch
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOT_NUM_W-1:0] slot_address_ff;
   logic                  a_valid_ff, a_valid_in;
   logic [7:0]            a_byte_ff;
   logic                  a_brk_ff;
   logic                  b_valid_ff, b_valid_in;
   result_type            b_res_ff;
   logic                  byp_valid_ff;
   logic [AW-1:0]         byp_addr_ff;
   logic [LEVEL_W-1:0]    byp_data_ff;
   logic                  b_adv;
   logic                  a_fire;
   logic                  req_fire;
   logic [AW-1:0]         rd_addr;
   logic [LEVEL_W-1:0]    rd_data;
   logic [LEVEL_W-1:0]    store_level;
   logic [SLOT_NUM_W-1:0] addr_m1;
   wr_cmd_type            wr;
   result_type            res;

   assign b_adv        = !b_valid_ff || rsp_ch.ready;
   assign a_fire       = a_valid_ff && b_adv;
   assign req_ch.ready = !a_valid_ff || b_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign a_valid_in = req_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);
   assign b_valid_in = a_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : b_valid_ff);

   assign addr_m1     = slot_address_ff - SLOT_NUM_W'(1);
   assign rd_addr     = addr_m1[AW-1:0];
   assign store_level = (byp_valid_ff && (byp_addr_ff == rd_addr)) ? byp_data_ff : rd_data;

   dmx_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr[AW-1:0]),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dmx_frame_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (a_fire),
      .in_byte      (a_byte_ff),
      .in_brk       (a_brk_ff),
      .slot_address (slot_address_ff),
      .store_level  (store_level),
      .wr           (wr),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_address_ff <= SLOT_ADDRESS_RESET;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         byp_valid_ff    <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (csr_ch.valid) begin
            slot_address_ff <= csr_ch.slot_address;
         end
         if (wr.en) begin
            byp_valid_ff <= 1'b1;
         end
      end
      if (req_fire) begin
         a_byte_ff <= req_ch.rx_byte;
         a_brk_ff  <= req_ch.break_seen;
      end
      if (a_fire) begin
         b_res_ff <= res;
      end
      if (wr.en) begin
         byp_addr_ff <= wr.addr[AW-1:0];
         byp_data_ff <= wr.data;
      end
   end

   assign rsp_ch.valid        = b_valid_ff;
   assign rsp_ch.level        = b_res_ff.level;
   assign rsp_ch.level_on     = b_res_ff.level_on;
   assign rsp_ch.slot_written = b_res_ff.slot_written;
   assign rsp_ch.slot_number  = b_res_ff.slot_number;

   a_written_number: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_res_ff.slot_written == (b_res_ff.slot_number != '0)))
      else $error("slot number disagrees with the written flag");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !rsp_ch.ready |=> b_valid_ff && $stable(b_res_ff))
      else $error("stalled result changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_adv |-> !req_ch.ready)
      else $error("input stage overrun while the result stage is full");

endmodule

/* rtl/core/dmx_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dmx_frame_ctrl.sv */
// ----------------------------------------------------------------------------
// DMX frame controller
// Tracks the frame phase, the slot counter and the fill mark of the slot
// store, latches the indicator level at each break and forms the result.
// ----------------------------------------------------------------------------
module dmx_frame_ctrl
   import dmx_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            in_byte,
   input  logic                  in_brk,
   input  logic [SLOT_NUM_W-1:0] slot_address,
   input  logic [LEVEL_W-1:0]    store_level,
   output wr_cmd_type            wr,
   output result_type            res
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_DATA,
      PH_SKIP
   } phase_type;

   localparam logic [SLOT_NUM_W-1:0] SLOTS_N = SLOT_NUM_W'(SLOTS);

   phase_type             phase_ff, phase_in;
   logic [SLOT_NUM_W-1:0] count_ff, count_in;
   logic [SLOT_NUM_W-1:0] fill_ff, fill_in;
   logic [LEVEL_W-1:0]    held_ff, held_in;
   logic [SLOT_NUM_W-1:0] addr_m1;
   logic [SLOT_NUM_W-1:0] count_p1;
   logic                  addr_ok;

   assign addr_m1  = slot_address - SLOT_NUM_W'(1);
   assign count_p1 = count_ff + SLOT_NUM_W'(1);
   assign addr_ok  = (slot_address != '0) && (slot_address <= SLOTS_N) && (addr_m1 < fill_ff);

   always_comb begin
      phase_in         = phase_ff;
      count_in         = count_ff;
      fill_in          = fill_ff;
      held_in          = held_ff;
      wr.en            = 1'b0;
      wr.addr          = count_ff[STORE_IDX_W-1:0];
      wr.data          = in_byte;
      res.slot_written = 1'b0;
      res.slot_number  = '0;
      if (in_brk) begin
         held_in  = addr_ok ? store_level : '0;
         phase_in = PH_START;
         count_in = '0;
      end else begin
         case (phase_ff)
            PH_START: begin
               phase_in = (in_byte == '0) ? PH_DATA : PH_SKIP;
               count_in = '0;
            end
            PH_DATA: begin
               if (count_ff < SLOTS_N) begin
                  wr.en            = fire;
                  count_in         = count_p1;
                  res.slot_written = 1'b1;
                  res.slot_number  = count_p1;
                  if (count_ff == fill_ff) begin
                     fill_in = count_p1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      res.level    = held_in;
      res.level_on = (held_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         fill_ff  <= '0;
         held_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         held_ff  <= held_in;
      end
   end

   a_wr_in_data: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (phase_ff == PH_DATA) && !in_brk && fire)
      else $error("slot store written outside the data phase");

   a_brk_restart: assert property (@(posedge clock) disable iff (reset)
      fire && in_brk |=> (phase_ff == PH_START) && (count_ff == '0))
      else $error("break did not restart the frame");

   a_fill_mark: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= fill_ff) && (fill_ff <= SLOTS_N))
      else $error("slot counter passed the fill mark");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill_ff >= $past(fill_ff))
      else $error("fill mark went down");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// DMX512 slot receiver testbench
// Streams received bytes, with and without break flags, into the receiver
// while both channels idle at random. Each accepted byte is run through a
// local model of the frame logic. Every result transaction is compared
// against the oldest predicted result. The indicator slot address is
// rewritten between phases, with in-range, zero and over-range values.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dmx_pkg::*;

   localparam int SLOT_COUNT  = SLOTS_DEFAULT;
   localparam int QUIET_LIMIT = 4000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_DATA,
      PH_SKIP
   } frame_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       brk;
   } rx_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dmx_req_if req_ch ();
   dmx_rsp_if rsp_ch ();
   dmx_csr_if csr_ch ();

   dmx512_slot_receiver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Local model of the frame logic.
   frame_phase_type       frame_phase;
   logic [9:0]            frame_slots;
   logic [7:0]            slot_levels [SLOT_COUNT];
   logic [7:0]            latched_level;
   logic [SLOT_NUM_W-1:0] indicator_address;

   rx_byte_type rx_pending [$];
   result_type  expected_results [$];

   rx_byte_type rx_current;
   bit          rx_busy;
   int unsigned rx_idle_left;
   int unsigned rx_calm;
   int unsigned rsp_stall_left;
   int unsigned rsp_calm;
   int unsigned quiet_cycles;
   int unsigned queued_bytes;
   int unsigned mismatches;
   result_type  oldest;

   function automatic result_type predict_slot(input logic [7:0] data, input logic brk);
      result_type r;
      r.slot_written = 1'b0;
      r.slot_number  = '0;
      if (brk) begin
         if (indicator_address >= 1 && indicator_address <= SLOT_COUNT) begin
            latched_level = slot_levels[9'(indicator_address - 10'd1)];
         end else begin
            latched_level = 8'h00;
         end
         frame_phase = PH_START;
         frame_slots = '0;
      end else if (frame_phase == PH_START) begin
         frame_phase = (data == 8'h00) ? PH_DATA : PH_SKIP;
         frame_slots = '0;
      end else if (frame_phase == PH_DATA && frame_slots < SLOT_COUNT) begin
         slot_levels[frame_slots[8:0]] = data;
         frame_slots    = frame_slots + 1'b1;
         r.slot_written = 1'b1;
         r.slot_number  = frame_slots;
      end
      r.level    = latched_level;
      r.level_on = (latched_level != 8'h00);
      return r;
   endfunction

   // Mostly no pause, some short ones, a few long ones, and now and then a
   // stretch of back-to-back cycles.
   function automatic int unsigned draw_pause(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [7:0] draw_level();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic check_field(input string field, input logic [9:0] want, input logic [9:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   task automatic push_rx(input logic [7:0] data, input logic brk);
      rx_byte_type b;
      b.data = data;
      b.brk  = brk;
      rx_pending.push_back(b);
      queued_bytes++;
   endtask

   task automatic queue_frames(input int unsigned min_bytes);
      int unsigned first;
      int unsigned kind;
      int unsigned n;
      first = queued_bytes;
      while (queued_bytes - first < min_bytes) begin
         kind = $urandom_range(0, 9);
         push_rx(8'($urandom), 1'b1);
         if (kind < 8) begin
            push_rx(8'h00, 1'b0);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
            repeat (n) push_rx(draw_level(), 1'b0);
         end else if (kind == 8) begin
            push_rx(8'($urandom_range(1, 255)), 1'b0);
            repeat ($urandom_range(0, 6)) push_rx(8'($urandom), 1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) push_rx(8'($urandom), $urandom_range(0, 3) == 0);
         end
      end
   endtask

   task automatic drain();
      do @(negedge clock); while (rx_pending.size() != 0 || rx_busy || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_slot_address(input logic [SLOT_NUM_W-1:0] value);
      @(posedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.slot_address <= value;
      do @(posedge clock); while (!csr_ch.ready);
      indicator_address = value;
      csr_ch.valid <= 1'b0;
   endtask

   // Byte driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_slot(rx_current.data, rx_current.brk));
            rx_busy      = 1'b0;
            rx_idle_left = draw_pause(rx_calm);
         end
         if (!rx_busy) begin
            if (rx_idle_left > 0) begin
               rx_idle_left--;
            end else if (rx_pending.size() != 0) begin
               rx_current = rx_pending.pop_front();
               rx_busy    = 1'b1;
            end
         end
         req_ch.valid      <= rx_busy;
         req_ch.rx_byte    <= rx_current.data;
         req_ch.break_seen <= rx_current.brk;
      end
   end

   // Result monitor and ready driver.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no byte outstanding");
            mismatches++;
         end else begin
            oldest = expected_results.pop_front();
            check_field("level", 10'(oldest.level), 10'(rsp_ch.level));
            check_field("level_on", 10'(oldest.level_on), 10'(rsp_ch.level_on));
            check_field("slot_written", 10'(oldest.slot_written), 10'(rsp_ch.slot_written));
            check_field("slot_number", oldest.slot_number, rsp_ch.slot_number);
         end
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_stall_left = draw_pause(rsp_calm);
         if (rsp_stall_left == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.rx_byte      = 8'h00;
      req_ch.break_seen   = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.slot_address = SLOT_ADDRESS_RESET;
      frame_phase         = PH_IDLE;
      frame_slots         = '0;
      latched_level       = 8'h00;
      indicator_address   = SLOT_ADDRESS_RESET;
      foreach (slot_levels[i]) slot_levels[i] = 8'h00;
      rx_busy        = 1'b0;
      rx_idle_left   = 0;
      rx_calm        = 0;
      rsp_stall_left = 0;
      rsp_calm       = 0;
      quiet_cycles   = 0;
      queued_bytes   = 0;
      mismatches     = 0;
      rx_current     = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Bytes before the first break are dropped.
      push_rx(8'hFF, 1'b0);
      push_rx(8'h00, 1'b0);
      // A normal frame; the data bits of the break byte are discarded.
      push_rx(8'hA5, 1'b1);
      push_rx(8'h00, 1'b0);
      push_rx(8'hFF, 1'b0);
      push_rx(8'h00, 1'b0);
      push_rx(8'h80, 1'b0);
      push_rx(8'h01, 1'b0);
      // Latch slot 1, then a frame with a nonzero start code is ignored.
      push_rx(8'h00, 1'b1);
      push_rx(8'hFF, 1'b0);
      push_rx(8'h7F, 1'b0);
      push_rx(8'h55, 1'b0);
      push_rx(8'h5A, 1'b1);
      push_rx(8'h01, 1'b0);
      // A zero level turns the indicator off; back-to-back breaks and an
      // empty frame leave the short-frame slots untouched.
      push_rx(8'hFF, 1'b1);
      push_rx(8'h00, 1'b0);
      push_rx(8'h00, 1'b0);
      push_rx(8'h3C, 1'b1);
      push_rx(8'hC3, 1'b1);
      push_rx(8'h00, 1'b0);
      push_rx(8'h0F, 1'b1);
      drain();

      // A full frame that runs past the last slot, then latch the last slot.
      write_slot_address(SLOT_NUM_W'(SLOT_COUNT));
      push_rx(8'hF0, 1'b1);
      push_rx(8'h00, 1'b0);
      repeat (SLOT_COUNT + 3) push_rx(draw_level(), 1'b0);
      push_rx(8'h81, 1'b1);
      queue_frames(60);
      drain();

      write_slot_address(10'd0);
      queue_frames(80);
      drain();

      write_slot_address(10'd1023);
      queue_frames(60);
      drain();

      write_slot_address(SLOT_NUM_W'(SLOT_COUNT + 1));
      queue_frames(40);
      drain();

      write_slot_address(10'd1);
      queue_frames(100);
      drain();

      write_slot_address(SLOT_NUM_W'($urandom_range(2, 30)));
      queue_frames(150);
      drain();

      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
